// ===== sv/rlpe_pkg.sv =====
package rlpe_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int AW            = 24;
  localparam int DW            = 32;
  localparam int FUNC_W        = 2;
  localparam int NIB_W         = 4;
  localparam int BYTE_W        = 8;
  localparam int STATUS_W      = 2;

  localparam logic [BYTE_W-1:0] SIGN_ADD = 8'd43;
  localparam logic [BYTE_W-1:0] SIGN_SUB = 8'd45;
  localparam logic [NIB_W-1:0]  MAX_NIB  = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FN_TEXT   = 2'd0,
    FN_MODIFY = 2'd1,
    FN_READ   = 2'd2,
    FN_XLATE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_SIGN = 2'd2
  } status_t;

  typedef enum logic {
    REG_ORIG_START = 1'b0,
    REG_LOAD_ADDR  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_READ,
    S_RLAST,
    S_CALC,
    S_WRITE,
    S_DONE
  } state_t;

  // bytes covering a field of nib nibbles
  function automatic logic [2:0] field_bytes(input logic [NIB_W-1:0] nib);
    logic [NIB_W:0] sum;
    sum = {1'b0, nib} + 5'd1;
    return sum[3:1];
  endfunction

endpackage

// ===== sv/rlpe_in_if.sv =====
interface rlpe_in_if;
  logic                           valid;
  logic                           ready;
  logic [rlpe_pkg::FUNC_W-1:0]    func;
  logic [rlpe_pkg::AW-1:0]        object_address;
  logic [rlpe_pkg::BYTE_W-1:0]    text_byte;
  logic [rlpe_pkg::NIB_W-1:0]     nibble_count;
  logic [rlpe_pkg::BYTE_W-1:0]    sign_char;

  modport source (output valid, func, object_address, text_byte, nibble_count, sign_char,
                  input ready);
  modport sink   (input valid, func, object_address, text_byte, nibble_count, sign_char,
                  output ready);
endinterface

// ===== sv/rlpe_out_if.sv =====
interface rlpe_out_if;
  logic                           valid;
  logic                           ready;
  logic [rlpe_pkg::BYTE_W-1:0]    read_byte;
  logic [rlpe_pkg::AW-1:0]        relocated_address;
  logic [rlpe_pkg::STATUS_W-1:0]  status;

  modport source (output valid, read_byte, relocated_address, status, input ready);
  modport sink   (input valid, read_byte, relocated_address, status, output ready);
endinterface

// ===== sv/rlpe_cfg_if.sv =====
interface rlpe_cfg_if;
  logic                       valid;
  logic                       ready;
  logic                       index;
  logic [rlpe_pkg::AW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/rlpe_store.sv =====
module rlpe_store #(
  parameter int ADDR_BITS = rlpe_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [rlpe_pkg::BYTE_W-1:0] wdata,
  output logic [rlpe_pkg::BYTE_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [rlpe_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/rlpe_ctrl.sv =====
module rlpe_ctrl #(
  parameter int ADDR_BITS = rlpe_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  rlpe_cfg_if.sink                    cfg,
  rlpe_in_if.sink                     item,
  rlpe_out_if.source                  result,
  output logic                        mem_we,
  output logic [ADDR_BITS-1:0]        mem_addr,
  output logic [rlpe_pkg::BYTE_W-1:0] mem_wdata,
  input  logic [rlpe_pkg::BYTE_W-1:0] mem_rdata
);

  localparam int DW = rlpe_pkg::DW;
  localparam int AW = rlpe_pkg::AW;

  rlpe_pkg::state_t state, state_next;

  logic [AW-1:0]                   orig;
  logic [AW-1:0]                   load;
  logic [DW-1:0]                   delta;

  rlpe_pkg::func_t                 func_q;
  logic [AW-1:0]                   obj_q;
  logic [rlpe_pkg::BYTE_W-1:0]     tbyte_q;
  logic [rlpe_pkg::NIB_W-1:0]      nib_q;
  logic [rlpe_pkg::BYTE_W-1:0]     sign_q;

  logic [DW-1:0]                   target;
  rlpe_pkg::status_t               status_q;
  logic [2:0]                      nbytes;
  logic [1:0]                      cnt;
  logic                            rd_pend;
  logic [DW-1:0]                   agg;
  logic [DW-1:0]                   nv;
  logic [ADDR_BITS-1:0]            clr_addr;

  logic                            out_valid;
  logic [rlpe_pkg::BYTE_W-1:0]     out_byte;
  logic [AW-1:0]                   out_addr;
  logic [rlpe_pkg::STATUS_W-1:0]   out_status;

  logic                            accept;
  logic                            out_free;
  logic                            last;
  logic                            len_bad;
  logic                            sign_bad;
  rlpe_pkg::status_t               status_c;
  logic [1:0]                      byte_idx;
  logic [ADDR_BITS-1:0]            byte_addr;
  logic [DW-1:0]                   mask;
  logic [DW-1:0]                   field;
  logic [DW-1:0]                   sum;
  logic [DW-1:0]                   newf;
  logic [DW-1:0]                   nv_c;

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;
  assign last     = ({1'b0, cnt} == (nbytes - 3'd1));
  assign byte_idx = 2'(nbytes - 3'd1 - {1'b0, cnt});
  assign byte_addr = target[ADDR_BITS-1:0] + ADDR_BITS'(cnt);

  assign len_bad  = (nib_q == '0) || (nib_q > rlpe_pkg::MAX_NIB);
  assign sign_bad = !(sign_q inside {rlpe_pkg::SIGN_ADD, rlpe_pkg::SIGN_SUB});

  always_comb begin
    status_c = rlpe_pkg::ST_OK;
    if (func_q == rlpe_pkg::FN_MODIFY) begin
      if (len_bad) begin
        status_c = rlpe_pkg::ST_BAD_LEN;
      end else if (sign_bad) begin
        status_c = rlpe_pkg::ST_BAD_SIGN;
      end
    end
  end

  // field patch: odd count keeps the low nibble
  always_comb begin
    mask  = DW'((33'd1 << {nib_q, 2'b00}) - 33'd1);
    field = (nib_q[0] ? (agg >> 4) : agg) & mask;
    sum   = (sign_q == rlpe_pkg::SIGN_ADD) ? field + delta : field - delta;
    newf  = sum & mask;
    nv_c  = nib_q[0] ? ((newf << 4) | {28'd0, agg[3:0]}) : newf;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rlpe_pkg::S_CLEAR: begin
        if (&clr_addr) state_next = rlpe_pkg::S_IDLE;
      end
      rlpe_pkg::S_IDLE: begin
        if (accept) state_next = rlpe_pkg::S_PREP;
      end
      rlpe_pkg::S_PREP: begin
        case (func_q)
          rlpe_pkg::FN_TEXT:   state_next = rlpe_pkg::S_WRITE;
          rlpe_pkg::FN_READ:   state_next = rlpe_pkg::S_READ;
          rlpe_pkg::FN_MODIFY: begin
            state_next = (status_c == rlpe_pkg::ST_OK) ? rlpe_pkg::S_READ : rlpe_pkg::S_DONE;
          end
          default:             state_next = rlpe_pkg::S_DONE;
        endcase
      end
      rlpe_pkg::S_READ: begin
        if (last) state_next = rlpe_pkg::S_RLAST;
      end
      rlpe_pkg::S_RLAST: begin
        state_next = (func_q == rlpe_pkg::FN_MODIFY) ? rlpe_pkg::S_CALC : rlpe_pkg::S_DONE;
      end
      rlpe_pkg::S_CALC: begin
        state_next = rlpe_pkg::S_WRITE;
      end
      rlpe_pkg::S_WRITE: begin
        if (last) state_next = rlpe_pkg::S_DONE;
      end
      rlpe_pkg::S_DONE: begin
        if (out_free) state_next = rlpe_pkg::S_IDLE;
      end
      default: state_next = rlpe_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = byte_addr;
    mem_wdata  = nv[{byte_idx, 3'b000} +: 8];
    case (state)
      rlpe_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      rlpe_pkg::S_IDLE:  item.ready = 1'b1;
      rlpe_pkg::S_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  assign cfg.ready                = 1'b1;
  assign result.valid             = out_valid;
  assign result.read_byte         = out_byte;
  assign result.relocated_address = out_addr;
  assign result.status            = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlpe_pkg::S_CLEAR;
      clr_addr  <= '0;
      orig      <= '0;
      load      <= '0;
      delta     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      cnt       <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == rlpe_pkg::S_READ);

      if (state == rlpe_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_BITS'(1);
      end

      if (cfg.valid) begin
        if (cfg.index == rlpe_pkg::REG_ORIG_START) begin
          orig  <= cfg.data;
          delta <= {8'd0, load} - {8'd0, cfg.data};
        end else begin
          load  <= cfg.data;
          delta <= {8'd0, cfg.data} - {8'd0, orig};
        end
      end

      if (state == rlpe_pkg::S_READ || state == rlpe_pkg::S_WRITE) begin
        cnt <= last ? 2'd0 : cnt + 2'd1;
      end

      if (state == rlpe_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= rlpe_pkg::func_t'(item.func);
      obj_q   <= item.object_address;
      tbyte_q <= item.text_byte;
      nib_q   <= item.nibble_count;
      sign_q  <= item.sign_char;
    end

    if (rd_pend) begin
      agg <= {agg[DW-9:0], mem_rdata};
    end

    case (state)
      rlpe_pkg::S_PREP: begin
        target   <= {8'd0, obj_q} + delta;
        status_q <= status_c;
        agg      <= '0;
        nv       <= {24'd0, tbyte_q};
        nbytes   <= (func_q == rlpe_pkg::FN_MODIFY) ? rlpe_pkg::field_bytes(nib_q) : 3'd1;
      end
      rlpe_pkg::S_CALC: begin
        nv <= nv_c;
      end
      rlpe_pkg::S_DONE: begin
        if (out_free) begin
          out_byte   <= (func_q == rlpe_pkg::FN_READ) ? agg[7:0] : '0;
          out_addr   <= target[AW-1:0];
          out_status <= status_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/relocating_load_patch_engine_unit.sv =====
// Path from accepted word to result: translate, rejected modify PREP, DONE; text PREP,
// WRITE, DONE; read PREP, READ, RLAST, DONE; modify PREP, READ, RLAST, CALC, WRITE, DONE.
// One word in flight; the next word is taken the cycle after its result is registered.
// The single-port byte store sets the modify time: reads then writes 1 to 4 bytes, one byte per cycle.
// Synchronous reset clears all 2**ADDR_BITS store bytes in one pass; no words accepted
// during the pass, configuration writes are still taken.
module relocating_load_patch_engine_unit #(
  parameter int ADDR_BITS = rlpe_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rlpe_cfg_if.sink    cfg,
  rlpe_in_if.sink     item,
  rlpe_out_if.source  result
);

  logic                        mem_we;
  logic [ADDR_BITS-1:0]        mem_addr;
  logic [rlpe_pkg::BYTE_W-1:0] mem_wdata;
  logic [rlpe_pkg::BYTE_W-1:0] mem_rdata;

  rlpe_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .result    (result),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rlpe_store #(.ADDR_BITS(ADDR_BITS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ===== sv/rlpe_chk.sv =====
module rlpe_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [rlpe_pkg::BYTE_W-1:0]   res_byte,
  input logic [rlpe_pkg::AW-1:0]       res_addr,
  input logic [rlpe_pkg::STATUS_W-1:0] res_status
);

  // one word in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("word accepted while previous word in progress");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_addr) && $stable(res_byte) && $stable(res_status))
    else $error("result word changed while stalled");

  // error status only comes from a modify word, which never returns a byte
  a_err_no_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != rlpe_pkg::ST_OK) |-> (res_byte == '0))
    else $error("error status with nonzero read byte");

endmodule

bind relocating_load_patch_engine_unit rlpe_chk u_rlpe_chk (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_byte   (result.read_byte),
  .res_addr   (result.relocated_address),
  .res_status (result.status)
);
